@@ rtl/core/linear_interpolation_table_assert.svh @@
// Assertion macros shared by the interpolation table RTL.
// Depends on nothing; included by the top level.
`ifndef LINEAR_INTERPOLATION_TABLE_ASSERT_SVH
`define LINEAR_INTERPOLATION_TABLE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LIT_ASSERT_SAME(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("interpolation table assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define LIT_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("interpolation table assertion failed");

`endif

@@ rtl/core/lit_pkg.sv @@
// Shared types, codes and helper functions for the interpolation table.
// Depends on nothing; used by every module of the block but lit_ram.
`timescale 1ns / 1ps

package lit_pkg;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [1:0] CLAMP_NONE = 2'd0;
    localparam logic [1:0] CLAMP_LOW  = 2'd1;
    localparam logic [1:0] CLAMP_HIGH = 2'd2;

    // Dividend is the exact product of two 33-bit magnitudes.
    localparam int DIV_NUM_W = 65;
    localparam int DIV_DEN_W = 33;

    typedef struct packed {
        logic              op;
        logic [7:0]        entry_index;
        logic signed [31:0] entry_x;
        logic signed [31:0] entry_y;
        logic signed [31:0] query_x;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] interp_value;
        logic [1:0]         clamp_code;
    } out_item_t;

    typedef struct packed {
        logic     valid;
        in_item_t item;
    } link_t;

    function automatic logic [32:0] mag33(input logic signed [32:0] v);
        return v[32] ? 33'(-v) : 33'(v);
    endfunction

endpackage

@@ rtl/core/lit_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps

module lit_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/lit_div.sv @@
// Restoring divider, one quotient bit per cycle.
// Depends on lit_pkg for operand widths.
`timescale 1ns / 1ps

module lit_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [lit_pkg::DIV_NUM_W-1:0]  dividend,
    input  logic [lit_pkg::DIV_DEN_W-1:0]  divisor,
    output logic                           done,
    output logic [lit_pkg::DIV_NUM_W-1:0]  quotient
);

    localparam int NW = lit_pkg::DIV_NUM_W;
    localparam int DW = lit_pkg::DIV_DEN_W;
    localparam int CW = $clog2(NW);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [NW-1:0] num_reg, num_next;
    logic [NW-1:0] quo_reg, quo_next;
    logic [DW-1:0] den_reg, den_next;
    logic [DW-1:0] rem_reg, rem_next;
    logic [DW:0]   rem_sh;
    logic          ge;

    always_comb
    begin
        rem_sh    = {rem_reg, num_reg[NW-1]};
        ge        = (rem_sh >= {1'b0, den_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(NW - 1);
            num_next  = dividend;
            den_next  = divisor;
            rem_next  = '0;
            quo_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? DW'(rem_sh - {1'b0, den_reg}) : DW'(rem_sh);
            quo_next = {quo_reg[NW-2:0], ge};
            num_next = {num_reg[NW-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

@@ rtl/core/lit_front.sv @@
// Front end: two-entry input queue that decouples accepting items from executing them.
// Depends on lit_pkg for the item and link types.
`timescale 1ns / 1ps

module lit_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  lit_pkg::in_item_t item,
    output lit_pkg::link_t    link,
    input  logic              take
);

    lit_pkg::in_item_t slot_reg [2];
    logic [1:0] count_reg, count_next;
    logic       wr_ptr_reg, rd_ptr_reg;
    logic       push_ok, take_ok;

    assign full    = (count_reg == 2'd2);
    assign push_ok = push && !full;
    assign take_ok = take && (count_reg != 2'd0);

    always_comb
    begin
        count_next = count_reg;
        case ({push_ok, take_ok})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (push_ok)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (take_ok)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            slot_reg[wr_ptr_reg] <= item;
        end
    end

    assign link.valid = (count_reg != 2'd0);
    assign link.item  = slot_reg[rd_ptr_reg];

endmodule

@@ rtl/core/lit_back.sv @@
// Back end: table memories, binary search, interpolation datapath and result register.
// Depends on lit_pkg, lit_ram and lit_div.
`timescale 1ns / 1ps

module lit_back #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  lit_pkg::link_t     link,
    output logic               take,
    input  logic [8:0]         points_in_use,
    input  logic               pop,
    output logic               empty,
    output lit_pkg::out_item_t result
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int NW = $clog2(TABLE_DEPTH + 1);
    localparam int CW = (NW > 9) ? NW : 9;
    localparam logic [64:0] MAG_CAP = 65'd1 << 40;

    typedef enum logic [10:0] {
        ST_IDLE   = 11'b00000000001,
        ST_SRCH   = 11'b00000000010,
        ST_CMP    = 11'b00000000100,
        ST_CLAMP  = 11'b00000001000,
        ST_FETCH1 = 11'b00000010000,
        ST_FETCH2 = 11'b00000100000,
        ST_MUL0   = 11'b00001000000,
        ST_MUL1   = 11'b00010000000,
        ST_DSTART = 11'b00100000000,
        ST_DIV    = 11'b01000000000,
        ST_OUT    = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;

    logic [NW-1:0] lo_reg, lo_next, hi_reg, hi_next, n_reg, n_next;
    logic [AW-1:0] mid_reg, mid_next;
    logic signed [31:0] q_reg, q_next, x1_reg, x1_next, y1_reg, y1_next;
    logic [32:0]   a_reg, a_next, b_reg, b_next, den_reg, den_next;
    logic          neg_reg, neg_next;
    logic [64:0]   prod_reg, prod_next;
    lit_pkg::out_item_t res_reg, res_next, out_reg;
    logic          out_valid_reg;
    logic          out_load;

    logic [AW-1:0] rd_addr, wr_addr;
    logic          wr_en;
    logic signed [31:0] x_rd, y_rd;
    logic [NW:0]   mid_sum;
    logic [NW-1:0] mid_full;
    logic [CW-1:0] pin_ext;
    logic signed [32:0] span, dq, dy;
    logic [16:0]   b_sel;
    logic [49:0]   pp;
    logic          div_start, div_done;
    logic [64:0]   quo;
    logic [40:0]   mag;
    logic signed [42:0] sum;

    lit_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_x_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (link.item.entry_x),
        .raddr (rd_addr),
        .rdata (x_rd)
    );

    lit_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_y_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (link.item.entry_y),
        .raddr (rd_addr),
        .rdata (y_rd)
    );

    lit_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_reg),
        .divisor  (den_reg),
        .done     (div_done),
        .quotient (quo)
    );

    assign take    = (state_reg == ST_IDLE) && link.valid;
    assign wr_addr = AW'(link.item.entry_index);
    assign wr_en   = take && (link.item.op == lit_pkg::OP_LOAD)
                     && (32'(link.item.entry_index) < 32'(TABLE_DEPTH));
    assign pin_ext = CW'(points_in_use);
    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid_full = NW'(mid_sum >> 1);
    assign span    = {x_rd[31], x_rd} - {x1_reg[31], x1_reg};
    assign dq      = {q_reg[31], q_reg} - {x1_reg[31], x1_reg};
    assign dy      = {y_rd[31], y_rd} - {y1_reg[31], y1_reg};
    assign b_sel   = (state_reg == ST_MUL0) ? b_reg[16:0] : {1'b0, b_reg[32:17]};
    assign pp      = a_reg * b_sel;
    assign div_start = (state_reg == ST_DSTART);
    assign mag     = (quo > MAG_CAP) ? 41'(MAG_CAP) : quo[40:0];
    assign sum     = neg_reg ? (43'(y1_reg) - 43'(mag)) : (43'(y1_reg) + 43'(mag));

    always_comb
    begin
        state_next = state_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        n_next     = n_reg;
        mid_next   = mid_reg;
        q_next     = q_reg;
        x1_next    = x1_reg;
        y1_next    = y1_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        den_next   = den_reg;
        neg_next   = neg_reg;
        prod_next  = prod_reg;
        res_next   = res_reg;
        rd_addr    = mid_reg;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (take && (link.item.op == lit_pkg::OP_QUERY))
                begin
                    if (pin_ext == '0)
                    begin
                        n_next = NW'(1);
                    end
                    else if (pin_ext > CW'(TABLE_DEPTH))
                    begin
                        n_next = NW'(TABLE_DEPTH);
                    end
                    else
                    begin
                        n_next = NW'(pin_ext);
                    end
                    lo_next    = '0;
                    hi_next    = n_next;
                    q_next     = link.item.query_x;
                    state_next = ST_SRCH;
                end
            end
            ST_SRCH:
            begin
                if (lo_reg < hi_reg)
                begin
                    rd_addr    = AW'(mid_full);
                    mid_next   = AW'(mid_full);
                    state_next = ST_CMP;
                end
                else if (lo_reg >= n_reg)
                begin
                    rd_addr             = AW'(n_reg - 1'b1);
                    res_next.clamp_code = lit_pkg::CLAMP_HIGH;
                    state_next          = ST_CLAMP;
                end
                else if (lo_reg == '0)
                begin
                    rd_addr             = '0;
                    res_next.clamp_code = lit_pkg::CLAMP_LOW;
                    state_next          = ST_CLAMP;
                end
                else
                begin
                    rd_addr    = AW'(lo_reg - 1'b1);
                    state_next = ST_FETCH1;
                end
            end
            ST_CMP:
            begin
                if (x_rd < q_reg)
                begin
                    lo_next = NW'(mid_reg) + 1'b1;
                end
                else
                begin
                    hi_next = NW'(mid_reg);
                end
                state_next = ST_SRCH;
            end
            ST_CLAMP:
            begin
                res_next.interp_value = y_rd;
                state_next            = ST_OUT;
            end
            ST_FETCH1:
            begin
                x1_next    = x_rd;
                y1_next    = y_rd;
                rd_addr    = AW'(lo_reg);
                state_next = ST_FETCH2;
            end
            ST_FETCH2:
            begin
                if (span == '0)
                begin
                    res_next.interp_value = y1_reg;
                    res_next.clamp_code   = lit_pkg::CLAMP_NONE;
                    state_next            = ST_OUT;
                end
                else
                begin
                    a_next     = lit_pkg::mag33(dq);
                    b_next     = lit_pkg::mag33(dy);
                    den_next   = lit_pkg::mag33(span);
                    neg_next   = dq[32] ^ dy[32] ^ span[32];
                    state_next = ST_MUL0;
                end
            end
            ST_MUL0:
            begin
                prod_next  = 65'(pp);
                state_next = ST_MUL1;
            end
            ST_MUL1:
            begin
                prod_next  = prod_reg + 65'({pp, 17'd0});
                state_next = ST_DSTART;
            end
            ST_DSTART:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    if (sum > 43'sd2147483647)
                    begin
                        res_next.interp_value = 32'sh7FFFFFFF;
                    end
                    else if (sum < -43'sd2147483648)
                    begin
                        res_next.interp_value = 32'sh80000000;
                    end
                    else
                    begin
                        res_next.interp_value = 32'(sum);
                    end
                    res_next.clamp_code = lit_pkg::CLAMP_NONE;
                    state_next          = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        n_reg    <= n_next;
        mid_reg  <= mid_next;
        q_reg    <= q_next;
        x1_reg   <= x1_next;
        y1_reg   <= y1_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        den_reg  <= den_next;
        neg_reg  <= neg_next;
        prod_reg <= prod_next;
        res_reg  <= res_next;
        if (out_load)
        begin
            out_reg <= res_reg;
        end
    end

    assign empty  = !out_valid_reg;
    assign result = out_reg;

endmodule

@@ rtl/core/linear_interpolation_table.sv @@
// Piecewise linear interpolation over a table of signed Q16.16 breakpoints.
// An interpolating query runs a binary search over the n points in use, then the 65-step
// bit-serial divider. Queries run one at a time; a clamped query skips the divider, and a
// load only writes its table entry and gives no result.
// Reset clears queues and control state and sets points_in_use to 2; table is undefined.
`timescale 1ns / 1ps
`include "linear_interpolation_table_assert.svh"

module linear_interpolation_table #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    // Item queue side.
    input  logic               push,
    output logic               full,
    input  lit_pkg::in_item_t  item,
    // Result queue side.
    input  logic               pop,
    output logic               empty,
    output lit_pkg::out_item_t result,
    // Configuration port.
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    // The only register, points_in_use, lives at byte address 0. It is read
    // by the back end when a query is taken from the queue, so a write made
    // while the block is idle governs every later query.
    logic [8:0] points_reg;
    logic       cfg_wr;

    lit_pkg::link_t link;
    logic           take;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
    assign prdata = (paddr[2] == 1'b0) ? {23'd0, points_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            points_reg <= 9'd2;
        end
        else if (cfg_wr)
        begin
            points_reg <= pwdata[8:0];
        end
    end

    // The front end buffers up to two items, so a transfer can be accepted
    // while the back end is still busy on an earlier query.
    lit_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (full),
        .item  (item),
        .link  (link),
        .take  (take)
    );

    // The back end owns the table, runs each query to completion and holds
    // the finished result in an output register until it is popped.
    lit_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .link          (link),
        .take          (take),
        .points_in_use (points_reg),
        .pop           (pop),
        .empty         (empty),
        .result        (result)
    );

    // The back end never takes an item from an empty queue.
    `LIT_ASSERT_SAME(a_take_valid, clk, rst_n, take, link.valid)
    // A full queue that is not drained stays full: no item is dropped.
    `LIT_ASSERT_NEXT(a_full_holds, clk, rst_n, full && !take && !pop, full)
    // A waiting result always carries one of the three defined codes.
    `LIT_ASSERT_SAME(a_code_range, clk, rst_n, !empty,
        result.clamp_code == lit_pkg::CLAMP_NONE ||
        result.clamp_code == lit_pkg::CLAMP_LOW ||
        result.clamp_code == lit_pkg::CLAMP_HIGH)

endmodule
